/* rtl/rpdc_pkg.sv */
// ----------------------------------------------------------------------------
// rpdc_pkg: shared types and constants for the profile drift compare block
// Sequencer states, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package rpdc_pkg;

    typedef enum logic [18:0] {
        S_IDLE  = 19'h00001,
        S_SQ    = 19'h00002,
        S_GSQRT = 19'h00004,
        S_NORM  = 19'h00008,
        S_LSQA  = 19'h00010,
        S_LSQB  = 19'h00020,
        S_DBMUL = 19'h00040,
        S_DBRND = 19'h00080,
        S_DBSQ  = 19'h00100,
        S_DBACC = 19'h00200,
        S_CINIT = 19'h00400,
        S_CORD  = 19'h00800,
        S_PH    = 19'h01000,
        S_PHSQ  = 19'h02000,
        S_PHACC = 19'h04000,
        S_FIN   = 19'h08000,
        S_DIV   = 19'h10000,
        S_RSQRT = 19'h20000,
        S_EMIT  = 19'h40000
    } state_t;

    localparam int SUM_W = 48;

    localparam logic [5:0] SQ_LAST    = 6'd6;
    localparam logic [5:0] SQRT_LAST  = 6'd23;
    localparam logic [5:0] LOG_LAST   = 6'd15;
    localparam logic [5:0] CORD_LAST  = 6'd15;
    localparam logic [5:0] DIV_LAST   = 6'd47;

    localparam logic [31:0] LEVEL_K  = 32'd197283;
    localparam logic [40:0] DB_ROUND = 41'd8388608;

    localparam logic signed [26:0] QUARTER_TURN = 27'sd5898240;
    localparam logic signed [26:0] HALF_TURN    = 27'sd11796480;
    localparam logic signed [26:0] FULL_TURN    = 27'sd23592960;

    localparam logic [25:0] PH_ROUND = 26'd512;

    // arctan(2^-i) in 1/65536 degree
    function automatic logic signed [26:0] atan_q16(input logic [3:0] i);
        logic signed [26:0] a;
        begin
            case (i)
                4'd0:    a = 27'sd2949120;
                4'd1:    a = 27'sd1740967;
                4'd2:    a = 27'sd919879;
                4'd3:    a = 27'sd466945;
                4'd4:    a = 27'sd234379;
                4'd5:    a = 27'sd117304;
                4'd6:    a = 27'sd58666;
                4'd7:    a = 27'sd29335;
                4'd8:    a = 27'sd14668;
                4'd9:    a = 27'sd7334;
                4'd10:   a = 27'sd3667;
                4'd11:   a = 27'sd1833;
                4'd12:   a = 27'sd917;
                4'd13:   a = 27'sd458;
                4'd14:   a = 27'sd229;
                4'd15:   a = 27'sd115;
                default: a = 27'sd0;
            endcase
            return a;
        end
    endfunction

endpackage

/* rtl/reflection_profile_drift_compare.sv */
// ----------------------------------------------------------------------------
// reflection_profile_drift_compare: reference vs. current reflection profile
// Accumulates squared gamma, level and phase differences over a profile and
// reports RMS values, the peak difference and the compared count.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transaction per pair of points (reference, current).
//   tlast marks the final point of the profile; tuser carries the two
//   valid flags. Master stream: one transaction per profile, after the point
//   marked tlast; tuser carries compare_ok.
//   Throughput: s_tready is high only while the sequencer is idle. An unused
//   or overflowing point needs no arithmetic. A compared point runs in turn
//   the squares, the difference square root, the two log2 evaluations
//   (normalize, then squaring) and the dB term, skipped if either magnitude
//   is zero, then the two CORDIC angles and the phase term; all run on one
//   shared 32x32 multiplier, one square-root and one divider step.
//   When compare_ok holds, the last point adds three 48-step divisions, each
//   followed by a 24-step square root.
//   The result sits in an output register, so the next point is taken while
//   a result waits; if the receiver stalls and a new result is ready, the
//   sequencer holds until the output register frees up.
//   Reset clears all accumulators, counters and the output valid.
// ----------------------------------------------------------------------------
module reflection_profile_drift_compare
    import rpdc_pkg::*;
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // base_freq[31:0], cur_freq[63:32], base_re[79:64], base_im[95:80],
    // cur_re[111:96], cur_im[127:112]
    input  logic [127:0] s_tdata,
    // base_valid[0], cur_valid[1]
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // compared_count[10:0], rms_gamma_diff[26:11], max_gamma_diff[42:27],
    // rms_level_db[58:43], rms_phase_deg[74:59], zero pad[79:75]
    output logic [79:0]  m_tdata,
    // compare_ok[0]
    output logic         m_tuser
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [SUM_W-1:0] a);
        logic [SUM_W:0] r;
        begin
            r = {1'b0, s} + {1'b0, a};
            return r[SUM_W] ? {SUM_W{1'b1}} : r[SUM_W-1:0];
        end
    endfunction

    function automatic logic [15:0] sat16(input logic [23:0] v);
        begin
            return (|v[23:16]) ? 16'hFFFF : v[15:0];
        end
    endfunction

    function automatic logic [16:0] abs17(input logic signed [16:0] v);
        begin
            return v[16] ? 17'(-v) : 17'(v);
        end
    endfunction

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    logic signed [15:0] br_reg, bi_reg, cr_reg, ci_reg;
    logic               last_reg;

    logic [CNT_W-1:0] points_reg, points_next;
    logic [CNT_W-1:0] pairs_reg, pairs_next;
    logic             ovf_reg, ovf_next;
    logic [SUM_W-1:0] sum_g_reg, sum_g_next;
    logic [SUM_W-1:0] sum_l_reg, sum_l_next;
    logic [SUM_W-1:0] sum_p_reg, sum_p_next;
    logic [15:0]      peak_reg, peak_next;

    logic [33:0] g2_reg, g2_next;
    logic [31:0] ma2_reg, ma2_next;
    logic [31:0] mb2_reg, mb2_next;
    logic [63:0] prod_reg;
    logic [31:0] mul_a, mul_b;

    logic [47:0] sq_in_reg, sq_in_next;
    logic [25:0] sq_rem_reg, sq_rem_next;
    logic [23:0] sq_root_reg, sq_root_next;
    logic [27:0] sq_rem_sh, sq_trial;
    logic [25:0] sq_rem_step;
    logic [23:0] sq_root_step;

    logic [31:0] lm_reg, lm_next;
    logic [4:0]  le_reg, le_next;
    logic [30:0] lmm_reg, lmm_next;
    logic [15:0] lf_reg, lf_next;
    logic        lsel_reg, lsel_next;
    logic [20:0] la_reg, la_next;
    logic [20:0] lb_reg, lb_next;
    logic [31:0] log_mm;
    logic [15:0] lf_step;
    logic [30:0] lmm_step;
    logic signed [21:0] lvl_diff;
    logic [20:0] lvl_abs;

    logic [15:0] db_reg, db_next;
    logic [40:0] db_sum;
    logic [15:0] ph_reg, ph_next;

    logic signed [26:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic signed [26:0] ang_a_reg, ang_a_next;
    logic               psel_reg, psel_next;
    logic signed [26:0] xs, ys, cx_step, cy_step, cz_step;
    logic signed [26:0] pre_re, pre_im, pre_x, pre_y, pre_z;
    logic signed [26:0] ph_d, ph_w;
    logic [25:0]        ph_abs;

    logic [1:0]       fsel_reg, fsel_next;
    logic [47:0]      dv_num_reg, dv_num_next;
    logic [CNT_W-1:0] dv_rem_reg, dv_rem_next;
    logic [CNT_W:0]   dv_sh;
    logic             dv_ge;
    logic [47:0]      dv_num_step;
    logic [CNT_W-1:0] dv_rem_step;

    logic [15:0] rms_g_reg, rms_g_next;
    logic [15:0] rms_l_reg, rms_l_next;
    logic [15:0] rms_p_reg, rms_p_next;
    logic        ok_reg, ok_next;
    logic        ok_calc;
    logic [CNT_W+6:0] pairs_x100, points_x60;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [79:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    logic        s_fire, in_used, out_free;
    logic signed [16:0] dre, dim;
    logic [16:0] sq_op;
    logic [15:0] dg;
    logic [CNT_W+10:0] count_ext;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_used  = s_tuser[0] && s_tuser[1] && (s_tdata[31:0] == s_tdata[63:32]);
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // squares of differences and magnitudes
    assign dre = {cr_reg[15], cr_reg} - {br_reg[15], br_reg};
    assign dim = {ci_reg[15], ci_reg} - {bi_reg[15], bi_reg};

    always_comb
    begin
        case (cnt_reg)
            6'd0:    sq_op = abs17(dre);
            6'd1:    sq_op = abs17(dim);
            6'd2:    sq_op = abs17({br_reg[15], br_reg});
            6'd3:    sq_op = abs17({bi_reg[15], bi_reg});
            6'd4:    sq_op = abs17({cr_reg[15], cr_reg});
            6'd5:    sq_op = abs17({ci_reg[15], ci_reg});
            default: sq_op = 17'd0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_SQ:
            begin
                mul_a = {15'd0, sq_op};
                mul_b = {15'd0, sq_op};
            end
            S_LSQA:
            begin
                mul_a = {1'b0, lmm_reg};
                mul_b = {1'b0, lmm_reg};
            end
            S_DBMUL:
            begin
                mul_a = {11'd0, lvl_abs};
                mul_b = LEVEL_K;
            end
            S_DBSQ:
            begin
                mul_a = {16'd0, db_reg};
                mul_b = {16'd0, db_reg};
            end
            S_PHSQ:
            begin
                mul_a = {16'd0, ph_reg};
                mul_b = {16'd0, ph_reg};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // square-root digit step
    assign sq_rem_sh = {sq_rem_reg, sq_in_reg[47:46]};
    assign sq_trial  = {2'b00, sq_root_reg, 2'b01};
    always_comb
    begin
        if (sq_rem_sh >= sq_trial)
        begin
            sq_rem_step  = 26'(sq_rem_sh - sq_trial);
            sq_root_step = {sq_root_reg[22:0], 1'b1};
        end
        else
        begin
            sq_rem_step  = sq_rem_sh[25:0];
            sq_root_step = {sq_root_reg[22:0], 1'b0};
        end
    end
    assign dg = sat16(sq_root_step);

    // log2 fraction step
    assign log_mm  = prod_reg[61:30];
    assign lf_step = {lf_reg[14:0], log_mm[31]};
    assign lmm_step = log_mm[31] ? log_mm[31:1] : log_mm[30:0];
    assign lvl_diff = $signed({1'b0, la_reg}) - $signed({1'b0, lb_reg});
    assign lvl_abs  = lvl_diff[21] ? 21'(-lvl_diff) : lvl_diff[20:0];
    assign db_sum   = prod_reg[40:0] + DB_ROUND;

    // CORDIC step
    assign xs = cx_reg >>> cnt_reg[3:0];
    assign ys = cy_reg >>> cnt_reg[3:0];
    always_comb
    begin
        if (cy_reg > 27'sd0)
        begin
            cx_step = cx_reg + ys;
            cy_step = cy_reg - xs;
            cz_step = cz_reg + atan_q16(cnt_reg[3:0]);
        end
        else
        begin
            cx_step = cx_reg - ys;
            cy_step = cy_reg + xs;
            cz_step = cz_reg - atan_q16(cnt_reg[3:0]);
        end
    end

    // quadrant pre-rotation
    always_comb
    begin
        if (psel_reg)
        begin
            pre_re = 27'(br_reg);
            pre_im = 27'(bi_reg);
        end
        else
        begin
            pre_re = 27'(cr_reg);
            pre_im = 27'(ci_reg);
        end
        if (pre_re < 27'sd0)
        begin
            if (pre_im >= 27'sd0)
            begin
                pre_x = pre_im;
                pre_y = -pre_re;
                pre_z = QUARTER_TURN;
            end
            else
            begin
                pre_x = -pre_im;
                pre_y = pre_re;
                pre_z = -QUARTER_TURN;
            end
        end
        else
        begin
            pre_x = pre_re;
            pre_y = pre_im;
            pre_z = 27'sd0;
        end
    end

    // phase wrap and magnitude
    assign ph_d = ang_a_reg - cz_reg;
    always_comb
    begin
        if (ph_d > HALF_TURN)
            ph_w = ph_d - FULL_TURN;
        else if (ph_d < -HALF_TURN)
            ph_w = ph_d + FULL_TURN;
        else
            ph_w = ph_d;
    end
    assign ph_abs = ph_w[26] ? 26'(-ph_w) : ph_w[25:0];

    // restoring divider step
    assign dv_sh = {dv_rem_reg, dv_num_reg[47]};
    assign dv_ge = dv_sh >= {1'b0, pairs_reg};
    assign dv_rem_step = dv_ge ? CNT_W'(dv_sh - {1'b0, pairs_reg}) : dv_sh[CNT_W-1:0];
    assign dv_num_step = {dv_num_reg[46:0], dv_ge};

    assign pairs_x100 = (CNT_W+7)'(pairs_reg) * (CNT_W+7)'(100);
    assign points_x60 = (CNT_W+7)'(points_reg) * (CNT_W+7)'(60);
    assign ok_calc = !ovf_reg && (points_reg >= CNT_W'(3)) && (pairs_reg != '0) &&
                     (pairs_x100 >= points_x60);
    assign count_ext = {11'd0, pairs_reg};

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        points_next  = points_reg;
        pairs_next   = pairs_reg;
        ovf_next     = ovf_reg;
        sum_g_next   = sum_g_reg;
        sum_l_next   = sum_l_reg;
        sum_p_next   = sum_p_reg;
        peak_next    = peak_reg;
        g2_next      = g2_reg;
        ma2_next     = ma2_reg;
        mb2_next     = mb2_reg;
        sq_in_next   = sq_in_reg;
        sq_rem_next  = sq_rem_reg;
        sq_root_next = sq_root_reg;
        lm_next      = lm_reg;
        le_next      = le_reg;
        lmm_next     = lmm_reg;
        lf_next      = lf_reg;
        lsel_next    = lsel_reg;
        la_next      = la_reg;
        lb_next      = lb_reg;
        db_next      = db_reg;
        ph_next      = ph_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        ang_a_next   = ang_a_reg;
        psel_next    = psel_reg;
        fsel_next    = fsel_reg;
        dv_num_next  = dv_num_reg;
        dv_rem_next  = dv_rem_reg;
        rms_g_next   = rms_g_reg;
        rms_l_next   = rms_l_reg;
        rms_p_next   = rms_p_reg;
        ok_next      = ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    if (points_reg >= CNT_W'(MAX_POINTS))
                    begin
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? S_FIN : S_IDLE;
                    end
                    else
                    begin
                        points_next = points_reg + CNT_W'(1);
                        cnt_next    = 6'd0;
                        if (in_used)
                            state_next = S_SQ;
                        else
                            state_next = s_tlast ? S_FIN : S_IDLE;
                    end
                end
            end
            S_SQ:
            begin
                case (cnt_reg)
                    6'd1:    g2_next  = prod_reg[33:0];
                    6'd2:    g2_next  = g2_reg + prod_reg[33:0];
                    6'd3:    mb2_next = prod_reg[31:0];
                    6'd4:    mb2_next = mb2_reg + prod_reg[31:0];
                    6'd5:    ma2_next = prod_reg[31:0];
                    6'd6:    ma2_next = ma2_reg + prod_reg[31:0];
                    default: g2_next  = g2_reg;
                endcase
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == SQ_LAST)
                begin
                    sq_in_next   = {14'd0, g2_reg};
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = 6'd0;
                    state_next   = S_GSQRT;
                end
            end
            S_GSQRT:
            begin
                sq_in_next   = {sq_in_reg[45:0], 2'b00};
                sq_rem_next  = sq_rem_step;
                sq_root_next = sq_root_step;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                begin
                    if (dg > peak_reg)
                        peak_next = dg;
                    sum_g_next = sat_add(sum_g_reg, {14'd0, g2_reg});
                    cnt_next   = 6'd0;
                    psel_next  = 1'b0;
                    if ((ma2_reg != 32'd0) && (mb2_reg != 32'd0))
                    begin
                        lm_next    = ma2_reg;
                        le_next    = 5'd31;
                        lsel_next  = 1'b0;
                        state_next = S_NORM;
                    end
                    else
                        state_next = S_CINIT;
                end
            end
            S_NORM:
            begin
                if (lm_reg[31])
                begin
                    lmm_next   = lm_reg[31:1];
                    lf_next    = '0;
                    cnt_next   = 6'd0;
                    state_next = S_LSQA;
                end
                else
                begin
                    lm_next = {lm_reg[30:0], 1'b0};
                    le_next = le_reg - 5'd1;
                end
            end
            S_LSQA:
            begin
                state_next = S_LSQB;
            end
            S_LSQB:
            begin
                lmm_next = lmm_step;
                lf_next  = lf_step;
                cnt_next = cnt_reg + 6'd1;
                state_next = S_LSQA;
                if (cnt_reg == LOG_LAST)
                begin
                    if (lsel_reg)
                    begin
                        lb_next    = {le_reg, lf_step};
                        state_next = S_DBMUL;
                    end
                    else
                    begin
                        la_next    = {le_reg, lf_step};
                        lsel_next  = 1'b1;
                        lm_next    = mb2_reg;
                        le_next    = 5'd31;
                        state_next = S_NORM;
                    end
                end
            end
            S_DBMUL:
            begin
                state_next = S_DBRND;
            end
            S_DBRND:
            begin
                db_next    = db_sum[39:24];
                state_next = S_DBSQ;
            end
            S_DBSQ:
            begin
                state_next = S_DBACC;
            end
            S_DBACC:
            begin
                sum_l_next = sat_add(sum_l_reg, prod_reg[SUM_W-1:0]);
                psel_next  = 1'b0;
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                cnt_next = 6'd0;
                if ((pre_re == 27'sd0) && (pre_im == 27'sd0))
                begin
                    // zero vector has angle zero
                    if (psel_reg)
                    begin
                        cz_next    = 27'sd0;
                        state_next = S_PH;
                    end
                    else
                    begin
                        ang_a_next = 27'sd0;
                        psel_next  = 1'b1;
                    end
                end
                else
                begin
                    cx_next    = pre_x <<< 8;
                    cy_next    = pre_y <<< 8;
                    cz_next    = pre_z;
                    state_next = S_CORD;
                end
            end
            S_CORD:
            begin
                cx_next  = cx_step;
                cy_next  = cy_step;
                cz_next  = cz_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == CORD_LAST)
                begin
                    if (psel_reg)
                        state_next = S_PH;
                    else
                    begin
                        ang_a_next = cz_step;
                        psel_next  = 1'b1;
                        state_next = S_CINIT;
                    end
                end
            end
            S_PH:
            begin
                ph_next    = 16'((ph_abs + PH_ROUND) >> 10);
                state_next = S_PHSQ;
            end
            S_PHSQ:
            begin
                state_next = S_PHACC;
            end
            S_PHACC:
            begin
                sum_p_next = sat_add(sum_p_reg, prod_reg[SUM_W-1:0]);
                pairs_next = pairs_reg + CNT_W'(1);
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                ok_next = ok_calc;
                cnt_next = 6'd0;
                if (ok_calc)
                begin
                    fsel_next   = 2'd0;
                    dv_num_next = sum_g_reg;
                    dv_rem_next = '0;
                    state_next  = S_DIV;
                end
                else
                begin
                    rms_g_next = '0;
                    rms_l_next = '0;
                    rms_p_next = '0;
                    state_next = S_EMIT;
                end
            end
            S_DIV:
            begin
                dv_num_next = dv_num_step;
                dv_rem_next = dv_rem_step;
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    sq_in_next   = dv_num_step;
                    sq_rem_next  = '0;
                    sq_root_next = '0;
                    cnt_next     = 6'd0;
                    state_next   = S_RSQRT;
                end
            end
            S_RSQRT:
            begin
                sq_in_next   = {sq_in_reg[45:0], 2'b00};
                sq_rem_next  = sq_rem_step;
                sq_root_next = sq_root_step;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == SQRT_LAST)
                begin
                    cnt_next    = 6'd0;
                    dv_rem_next = '0;
                    case (fsel_reg)
                        2'd0:
                        begin
                            rms_g_next  = dg;
                            dv_num_next = sum_l_reg;
                            fsel_next   = 2'd1;
                            state_next  = S_DIV;
                        end
                        2'd1:
                        begin
                            rms_l_next  = dg;
                            dv_num_next = sum_p_reg;
                            fsel_next   = 2'd2;
                            state_next  = S_DIV;
                        end
                        default:
                        begin
                            rms_p_next = dg;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = ok_reg;
                    m_tdata_next  = {5'd0, rms_p_reg, rms_l_reg,
                                     ok_reg ? peak_reg : 16'd0, rms_g_reg,
                                     count_ext[10:0]};
                    points_next = '0;
                    pairs_next  = '0;
                    ovf_next    = 1'b0;
                    sum_g_next  = '0;
                    sum_l_next  = '0;
                    sum_p_next  = '0;
                    peak_next   = '0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            points_reg   <= '0;
            pairs_reg    <= '0;
            ovf_reg      <= 1'b0;
            sum_g_reg    <= '0;
            sum_l_reg    <= '0;
            sum_p_reg    <= '0;
            peak_reg     <= '0;
            lsel_reg     <= 1'b0;
            psel_reg     <= 1'b0;
            fsel_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            points_reg   <= points_next;
            pairs_reg    <= pairs_next;
            ovf_reg      <= ovf_next;
            sum_g_reg    <= sum_g_next;
            sum_l_reg    <= sum_l_next;
            sum_p_reg    <= sum_p_next;
            peak_reg     <= peak_next;
            lsel_reg     <= lsel_next;
            psel_reg     <= psel_next;
            fsel_reg     <= fsel_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            br_reg   <= s_tdata[79:64];
            bi_reg   <= s_tdata[95:80];
            cr_reg   <= s_tdata[111:96];
            ci_reg   <= s_tdata[127:112];
            last_reg <= s_tlast;
        end
        prod_reg    <= 64'(mul_a) * 64'(mul_b);
        g2_reg      <= g2_next;
        ma2_reg     <= ma2_next;
        mb2_reg     <= mb2_next;
        sq_in_reg   <= sq_in_next;
        sq_rem_reg  <= sq_rem_next;
        sq_root_reg <= sq_root_next;
        lm_reg      <= lm_next;
        le_reg      <= le_next;
        lmm_reg     <= lmm_next;
        lf_reg      <= lf_next;
        la_reg      <= la_next;
        lb_reg      <= lb_next;
        db_reg      <= db_next;
        ph_reg      <= ph_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        ang_a_reg   <= ang_a_next;
        dv_num_reg  <= dv_num_next;
        dv_rem_reg  <= dv_rem_next;
        rms_g_reg   <= rms_g_next;
        rms_l_reg   <= rms_l_next;
        rms_p_reg   <= rms_p_next;
        ok_reg      <= ok_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule

/* verif/tb_reflection_profile_drift_compare.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reflection_profile_drift_compare: self-checking bench for the drift compare
// Drives point pairs on the slave stream and models the expected profile
// result of each tlast frame. Compares every master transaction field by field.
// ----------------------------------------------------------------------------
module tb_reflection_profile_drift_compare;

    localparam int MAX_PTS     = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    localparam longint unsigned ACC_MAX = (64'd1 << 48) - 1;
    localparam longint HALF_DEG = 180 * 65536;
    localparam longint FULL_DEG = 360 * 65536;

    typedef struct {
        logic [31:0]        base_freq;
        logic [31:0]        cur_freq;
        logic signed [15:0] base_re;
        logic signed [15:0] base_im;
        logic signed [15:0] cur_re;
        logic signed [15:0] cur_im;
        logic               base_valid;
        logic               cur_valid;
        logic               last_point;
    } point_t;

    typedef struct {
        logic        compare_ok;
        logic [10:0] compared_count;
        logic [15:0] rms_gamma_diff;
        logic [15:0] max_gamma_diff;
        logic [15:0] rms_level_db;
        logic [15:0] rms_phase_deg;
    } profile_t;

    typedef struct {
        point_t   pt;
        bit       fixed;
        profile_t res;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [79:0]  m_tdata;
    logic         m_tuser;

    reflection_profile_drift_compare #(.MAX_POINTS(MAX_PTS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    longint atan_deg[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    // model state
    int              seen_cnt;
    int              pair_cnt;
    longint unsigned gamma_acc;
    longint unsigned level_acc;
    longint unsigned phase_acc;
    int              peak_diff;
    bit              too_many;

    profile_t profile_q[$];
    int       fail_cnt;
    int       cycle_cnt;
    bit       quiet;
    int       rdy_hold;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (quiet || r < 50)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            if (r < 99)
                return $urandom_range(4, 20);
            return $urandom_range(50, 200);
        end
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        end
    endfunction

    function automatic logic [15:0] clip16(longint unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic longint log2_fix(longint unsigned x);
        int              e;
        longint unsigned m, f;
        begin
            e = 63;
            f = 0;
            while (e > 0 && !x[e])
                e--;
            m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
            for (int i = 0; i < 16; i++)
            begin
                m = (m * m) >> 30;
                f <<= 1;
                // hold the mantissa below 2.0
                if (m >= (64'd2 << 30))
                begin
                    m >>= 1;
                    f |= 1;
                end
            end
            return longint'(e) * 65536 + longint'(f);
        end
    endfunction

    function automatic longint angle_fix(longint re, longint im);
        longint x, y, z, t, xs, ys;
        begin
            x = re;
            y = im;
            z = 0;
            if (re == 0 && im == 0)
                return 0;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = 90 * 65536;
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -90 * 65536;
                end
            end
            x *= 256;
            y *= 256;
            for (int i = 0; i < 16; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0)
                begin
                    x += ys;
                    y -= xs;
                    z += atan_deg[i];
                end
                else
                begin
                    x -= ys;
                    y += xs;
                    z -= atan_deg[i];
                end
            end
            return z;
        end
    endfunction

    function automatic longint unsigned acc_add(longint unsigned s, longint unsigned a);
        return (s + a > ACC_MAX) ? ACC_MAX : s + a;
    endfunction

    task automatic add_pair(point_t p);
        longint          br, bi, cr, ci, dre, dim, l, d;
        longint unsigned g2, ma2, mb2, db, ph;
        int              dg;
        begin
            br = p.base_re;
            bi = p.base_im;
            cr = p.cur_re;
            ci = p.cur_im;
            dre = cr - br;
            dim = ci - bi;
            g2 = dre * dre + dim * dim;
            mb2 = br * br + bi * bi;
            ma2 = cr * cr + ci * ci;
            db = 0;
            if (ma2 != 0 && mb2 != 0)
            begin
                l = log2_fix(ma2) - log2_fix(mb2);
                if (l < 0)
                    l = -l;
                db = (longint'(l) * 197283 + (64'd1 << 23)) >> 24;
            end
            d = angle_fix(cr, ci) - angle_fix(br, bi);
            if (d > HALF_DEG)
                d -= FULL_DEG;
            else if (d < -HALF_DEG)
                d += FULL_DEG;
            if (d < 0)
                d = -d;
            ph = (d + 512) >> 10;
            dg = clip16(int_sqrt(g2));
            gamma_acc = acc_add(gamma_acc, g2);
            level_acc = acc_add(level_acc, db * db);
            phase_acc = acc_add(phase_acc, ph * ph);
            if (dg > peak_diff)
                peak_diff = dg;
            pair_cnt++;
        end
    endtask

    task automatic clear_profile();
        seen_cnt = 0;
        pair_cnt = 0;
        gamma_acc = 0;
        level_acc = 0;
        phase_acc = 0;
        peak_diff = 0;
        too_many = 0;
    endtask

    // advance the model by one point; return the profile result on tlast
    task automatic model_point(input point_t p, output bit done, output profile_t r);
        bit ok;
        begin
            done = 0;
            r = '{default: '0};
            if (seen_cnt >= MAX_PTS)
                too_many = 1;
            else
            begin
                seen_cnt++;
                if (p.base_valid && p.cur_valid && p.base_freq == p.cur_freq)
                    add_pair(p);
            end
            if (p.last_point)
            begin
                ok = !too_many && seen_cnt >= 3 && pair_cnt != 0 &&
                     longint'(pair_cnt) * 100 >= longint'(seen_cnt) * 60;
                done = 1;
                r.compare_ok = ok;
                r.compared_count = pair_cnt[10:0];
                if (ok)
                begin
                    r.rms_gamma_diff = clip16(int_sqrt(gamma_acc / pair_cnt));
                    r.max_gamma_diff = peak_diff[15:0];
                    r.rms_level_db = clip16(int_sqrt(level_acc / pair_cnt));
                    r.rms_phase_deg = clip16(int_sqrt(phase_acc / pair_cnt));
                end
                clear_profile();
            end
        end
    endtask

    // drive one transaction and wait for it to be taken
    task automatic send_point(point_t p, bit fixed, profile_t fixed_res);
        int       gap;
        bit       done;
        profile_t r;
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            s_tdata = {p.cur_im, p.cur_re, p.base_im, p.base_re, p.cur_freq, p.base_freq};
            s_tuser = {p.cur_valid, p.base_valid};
            s_tlast = p.last_point;
            s_tvalid = 1'b1;
            do
                @(posedge clk);
            while (!s_tready);
            model_point(p, done, r);
            if (done)
                profile_q.push_back(fixed ? fixed_res : r);
        end
    endtask

    function automatic point_t mk(logic [31:0] bf, logic [31:0] cf, int br, int bi,
                                  int cr, int ci, bit bv, bit cv, bit last);
        point_t p;
        begin
            p.base_freq = bf;
            p.cur_freq = cf;
            p.base_re = br;
            p.base_im = bi;
            p.cur_re = cr;
            p.cur_im = ci;
            p.base_valid = bv;
            p.cur_valid = cv;
            p.last_point = last;
            return p;
        end
    endfunction

    function automatic logic signed [15:0] edge_val();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic point_t rand_point(bit last);
        point_t p;
        int     r;
        begin
            p.base_freq = $urandom;
            p.cur_freq = p.base_freq;
            p.base_valid = 1'b1;
            p.cur_valid = 1'b1;
            p.last_point = last;
            p.base_re = $urandom;
            p.base_im = $urandom;
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                p.cur_re = $urandom;
                p.cur_im = $urandom;
            end
            else if (r < 80)
            begin
                p.cur_re = p.base_re + $signed(16'($urandom_range(0, 400)) - 16'sd200);
                p.cur_im = p.base_im + $signed(16'($urandom_range(0, 400)) - 16'sd200);
            end
            else if (r < 88)
            begin
                p.cur_re = p.base_re;
                p.cur_im = p.base_im;
            end
            else
            begin
                p.base_re = edge_val();
                p.base_im = edge_val();
                p.cur_re = edge_val();
                p.cur_im = edge_val();
            end
            r = $urandom_range(0, 99);
            if (r < 7)
                p.cur_freq = $urandom;
            else if (r < 10)
                p.cur_freq = p.base_freq ^ (32'd1 << $urandom_range(0, 31));
            else if (r < 20)
            begin
                p.base_valid = $urandom_range(0, 1);
                p.cur_valid = !p.base_valid ? $urandom_range(0, 1) : 1'b0;
            end
            return p;
        end
    endfunction

    // receiver: random back-pressure, check at the rising edge
    always @(negedge clk)
    begin
        if (rdy_hold > 0)
        begin
            m_tready = 1'b0;
            rdy_hold--;
        end
        else
        begin
            m_tready = 1'b1;
            rdy_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        profile_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (profile_q.size() == 0)
            begin
                $error("unexpected result transaction");
                fail_cnt++;
            end
            else
            begin
                e = profile_q.pop_front();
                if (m_tuser !== e.compare_ok)
                begin
                    $error("compare_ok exp %0d got %0d", e.compare_ok, m_tuser);
                    fail_cnt++;
                end
                if (m_tdata[10:0] !== e.compared_count)
                begin
                    $error("compared_count exp %0d got %0d", e.compared_count, m_tdata[10:0]);
                    fail_cnt++;
                end
                if (m_tdata[26:11] !== e.rms_gamma_diff)
                begin
                    $error("rms_gamma_diff exp %0d got %0d", e.rms_gamma_diff, m_tdata[26:11]);
                    fail_cnt++;
                end
                if (m_tdata[42:27] !== e.max_gamma_diff)
                begin
                    $error("max_gamma_diff exp %0d got %0d", e.max_gamma_diff, m_tdata[42:27]);
                    fail_cnt++;
                end
                if (m_tdata[58:43] !== e.rms_level_db)
                begin
                    $error("rms_level_db exp %0d got %0d", e.rms_level_db, m_tdata[58:43]);
                    fail_cnt++;
                end
                if (m_tdata[74:59] !== e.rms_phase_deg)
                begin
                    $error("rms_phase_deg exp %0d got %0d", e.rms_phase_deg, m_tdata[74:59]);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        row_t     rows[$];
        profile_t none;
        profile_t rej2;
        profile_t flat3;
        int       len;
        int       sent;
        int       r;
        int       wait_cnt;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        rdy_hold = 0;
        quiet = 0;
        fail_cnt = 0;
        cycle_cnt = 0;
        clear_profile();
        none = '{default: '0};
        rej2 = '{default: '0};
        rej2.compared_count = 11'd2;
        flat3 = '{default: '0};
        flat3.compare_ok = 1'b1;
        flat3.compared_count = 11'd3;

        // too few points
        rows.push_back('{mk(1000, 1000, 100, 200, 100, 200, 1, 1, 0), 0, none});
        rows.push_back('{mk(2000, 2000, -5, 7, -5, 7, 1, 1, 1), 1, rej2});
        // identical points at the extremes and at zero
        rows.push_back('{mk(3, 3, 32767, 32767, 32767, 32767, 1, 1, 0), 0, none});
        rows.push_back('{mk(4, 4, -32768, -32768, -32768, -32768, 1, 1, 0), 0, none});
        rows.push_back('{mk(5, 5, 0, 0, 0, 0, 1, 1, 1), 1, flat3});
        // largest difference, opposite phase, zero vector, unused pairs
        rows.push_back('{mk(0, 0, -32768, -32768, 32767, 32767, 1, 1, 0), 0, none});
        rows.push_back('{mk(32'hFFFFFFFF, 32'hFFFFFFFF, 32767, 0, -32768, 0, 1, 1, 0), 0, none});
        rows.push_back('{mk(5, 5, 8192, 0, 0, 0, 1, 1, 0), 0, none});
        rows.push_back('{mk(6, 6, 0, -32768, 0, 32767, 1, 1, 0), 0, none});
        rows.push_back('{mk(7, 8, 100, 100, 200, 200, 1, 1, 0), 0, none});
        rows.push_back('{mk(9, 9, 100, 100, 200, 200, 0, 1, 0), 0, none});
        rows.push_back('{mk(9, 9, 100, 100, 200, 200, 1, 0, 0), 0, none});
        rows.push_back('{mk(1, 1, 1, 1, -1, -1, 1, 1, 1), 0, none});
        // under 60 percent compared
        rows.push_back('{mk(10, 10, 50, 50, 60, 60, 1, 1, 0), 0, none});
        rows.push_back('{mk(11, 12, 50, 50, 60, 60, 1, 1, 0), 0, none});
        rows.push_back('{mk(13, 13, 50, 50, 60, 60, 0, 0, 0), 0, none});
        rows.push_back('{mk(14, 14, 50, 50, 60, 60, 0, 1, 0), 0, none});
        rows.push_back('{mk(15, 15, -50, 50, 60, -60, 1, 1, 1), 1, rej2});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_point(rows[i].pt, rows[i].fixed, rows[i].res);

        sent = 0;
        while (sent < 1680)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                len = $urandom_range(1, 2);
            else if (r < 80)
                len = $urandom_range(3, 12);
            else
                len = $urandom_range(13, 60);
            quiet = ($urandom_range(0, 7) == 0);
            for (int k = 0; k < len; k++)
                send_point(rand_point(k == len - 1), 0, none);
            sent += len;
            // one frame that runs past the point limit, mostly unused pairs
            if (sent > 300 && sent < 400)
            begin
                len = MAX_PTS + $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    point_t p;
                    p = rand_point(k == len - 1);
                    if (k % 10 != 0)
                        p.base_valid = 1'b0;
                    send_point(p, 0, none);
                end
                sent += 500;
            end
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        quiet = 1;
        wait_cnt = 0;
        while (profile_q.size() != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (400) @(posedge clk);
        if (fail_cnt == 0 && profile_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
